FILE: hw/rtl/met_pkg.sv
// Shared types and constants for the Mandelbrot escape-time block.
// Used by met_ctrl, met_datapath and mandelbrot_escape_time; no dependencies.
package met_pkg;

    localparam int MET_WORD_BITS     = 32;
    localparam int MET_FRACTION_BITS = 28;
    localparam int MET_COUNT_BITS    = 8;

    localparam logic [MET_COUNT_BITS-1:0] MET_LIMIT_RESET = 8'd100;

    // Controller to datapath
    typedef struct packed {
        logic load;          // capture c, start z = c, clear count
        logic mul;           // register re*re, im*im, re*im
        logic step;          // z = z*z + c, count + 1
        logic emit;          // load the result register
        logic emit_escaped;  // escape flag for the result register
    } met_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic escape;        // |z|^2 > 4 on the registered squares
        logic last;          // this step reaches the iteration limit
    } met_status_t;

endpackage

FILE: hw/rtl/met_datapath.sv
// Datapath of the escape-time block: orbit registers, three multipliers,
// escape test, saturating update, iteration counter and result register.
// Depends on met_pkg.
module met_datapath
    import met_pkg::*;
#(
    parameter int WORD_BITS     = MET_WORD_BITS,
    parameter int FRACTION_BITS = MET_FRACTION_BITS
) (
    input  logic                             aclk,
    input  met_cmd_t                         cmd,
    input  logic signed [WORD_BITS-1:0]      c_real,
    input  logic signed [WORD_BITS-1:0]      c_imag,
    input  logic        [MET_COUNT_BITS-1:0] iteration_limit,
    output met_status_t                      status,
    output logic        [MET_COUNT_BITS-1:0] escape_count,
    output logic                             escaped
);

    localparam int PROD_BITS = 2 * WORD_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int EXT_BITS  = PROD_BITS + 2;
    localparam int ESC_SHIFT = 2 * FRACTION_BITS + 2;
    localparam logic [SUM_BITS-1:0] ESC_BOUND = SUM_BITS'(1) << ESC_SHIFT;

    logic signed [WORD_BITS-1:0]      c_re_reg, c_im_reg;
    logic signed [WORD_BITS-1:0]      z_re_reg, z_im_reg;
    logic signed [WORD_BITS-1:0]      z_re_next, z_im_next;
    logic signed [PROD_BITS-1:0]      re_sq_reg, im_sq_reg, re_im_reg;
    logic        [MET_COUNT_BITS-1:0] count_reg;
    logic        [MET_COUNT_BITS-1:0] escape_count_reg;
    logic                             escaped_reg;

    logic        [SUM_BITS-1:0]       mag_sq;
    logic signed [EXT_BITS-1:0]       re_wide, im_wide;

    // Squares are non-negative, so the magnitude sum is an unsigned add
    assign mag_sq = SUM_BITS'($unsigned(re_sq_reg)) + SUM_BITS'($unsigned(im_sq_reg));
    assign status.escape = (mag_sq > ESC_BOUND);
    assign status.last   = ((MET_COUNT_BITS + 1)'(count_reg) + (MET_COUNT_BITS + 1)'(1))
                           == (MET_COUNT_BITS + 1)'(iteration_limit);

    // Floor shift back to the fixed-point scale, then add c
    assign re_wide = ((EXT_BITS'(re_sq_reg) - EXT_BITS'(im_sq_reg)) >>> FRACTION_BITS)
                     + EXT_BITS'(c_re_reg);
    assign im_wide = (EXT_BITS'(re_im_reg) >>> (FRACTION_BITS - 1))
                     + EXT_BITS'(c_im_reg);

    // Saturate to the signed word range
    always_comb begin
        if (&re_wide[EXT_BITS-1:WORD_BITS-1] || ~|re_wide[EXT_BITS-1:WORD_BITS-1]) begin
            z_re_next = re_wide[WORD_BITS-1:0];
        end else begin
            z_re_next = {re_wide[EXT_BITS-1], {(WORD_BITS-1){~re_wide[EXT_BITS-1]}}};
        end
        if (&im_wide[EXT_BITS-1:WORD_BITS-1] || ~|im_wide[EXT_BITS-1:WORD_BITS-1]) begin
            z_im_next = im_wide[WORD_BITS-1:0];
        end else begin
            z_im_next = {im_wide[EXT_BITS-1], {(WORD_BITS-1){~im_wide[EXT_BITS-1]}}};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            c_re_reg  <= c_real;
            c_im_reg  <= c_imag;
            z_re_reg  <= c_real;
            z_im_reg  <= c_imag;
            count_reg <= '0;
        end else if (cmd.step) begin
            z_re_reg  <= z_re_next;
            z_im_reg  <= z_im_next;
            count_reg <= count_reg + MET_COUNT_BITS'(1);
        end
        if (cmd.mul) begin
            re_sq_reg <= PROD_BITS'(z_re_reg) * PROD_BITS'(z_re_reg);
            im_sq_reg <= PROD_BITS'(z_im_reg) * PROD_BITS'(z_im_reg);
            re_im_reg <= PROD_BITS'(z_re_reg) * PROD_BITS'(z_im_reg);
        end
        if (cmd.emit) begin
            escape_count_reg <= count_reg;
            escaped_reg      <= cmd.emit_escaped;
        end
    end

    assign escape_count = escape_count_reg;
    assign escaped      = escaped_reg;

endmodule

FILE: hw/rtl/met_ctrl.sv
// Controller of the escape-time block: sequences load, multiply and update
// steps and owns the input ready and the result valid. Depends on met_pkg.
module met_ctrl
    import met_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  logic        limit_zero,
    input  met_status_t status,
    output met_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MULT,
        ST_EVAL,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   esc_reg, esc_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        esc_next   = esc_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    esc_next   = 1'b0;
                    // A zero limit makes no test at all
                    state_next = limit_zero ? ST_FINISH : ST_MULT;
                end
            end
            ST_MULT: begin
                cmd.mul    = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (status.escape) begin
                    esc_next   = 1'b1;
                    state_next = ST_FINISH;
                end else begin
                    cmd.step   = 1'b1;
                    state_next = status.last ? ST_FINISH : ST_MULT;
                end
            end
            ST_FINISH: begin
                // Hold until the result register is free or being drained
                if (!m_valid_reg || m_ready) begin
                    cmd.emit         = 1'b1;
                    cmd.emit_escaped = esc_reg;
                    state_next       = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            esc_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            esc_reg     <= esc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: hw/rtl/mandelbrot_escape_time.sv
// Mandelbrot escape-time unit. Each input transfer carries one point c in signed
// fixed point (WORD_BITS wide, FRACTION_BITS fraction bits); the unit iterates
// z = z*z + c from z = c and returns how many squarings completed before |z|
// exceeded two, or the iteration limit with escaped low. One point is worked at a
// time: each of its escape tests (at most the limit) passes through the multiply
// and the evaluate state. The result sits in an output register, so the next point
// is taken while a finished result waits. The limit is written through
// cfg_we/cfg_wdata only while the unit is idle; the user must keep to this, as
// the block does not enforce it. The limit resets to 100; a limit of zero returns
// count 0. Depends on met_pkg, met_ctrl and met_datapath.
module mandelbrot_escape_time
    import met_pkg::*;
#(
    parameter int WORD_BITS     = MET_WORD_BITS,
    parameter int FRACTION_BITS = MET_FRACTION_BITS,
    parameter int S_TDATA_BITS  = ((2 * WORD_BITS + 7) / 8) * 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      cfg_we,
    input  logic [MET_COUNT_BITS-1:0] cfg_wdata,      // iteration_limit

    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [S_TDATA_BITS-1:0]   s_axis_tdata,   // c_real, c_imag, zero pad

    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output logic [MET_COUNT_BITS-1:0] m_axis_tdata,   // escape_count
    output logic                      m_axis_tuser    // escaped
);

    logic [MET_COUNT_BITS-1:0]   limit_reg;
    logic signed [WORD_BITS-1:0] c_real, c_imag;
    met_cmd_t                    cmd;
    met_status_t                 status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= MET_LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    assign c_real = s_axis_tdata[WORD_BITS-1:0];
    assign c_imag = s_axis_tdata[2*WORD_BITS-1:WORD_BITS];

    met_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_ready    (s_axis_tready),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .limit_zero (limit_reg == '0),
        .status     (status),
        .cmd        (cmd)
    );

    met_datapath #(
        .WORD_BITS     (WORD_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .cmd             (cmd),
        .c_real          (c_real),
        .c_imag          (c_imag),
        .iteration_limit (limit_reg),
        .status          (status),
        .escape_count    (m_axis_tdata),
        .escaped         (m_axis_tuser)
    );

endmodule

FILE: tb/sv/tb_mandelbrot_escape_time.sv
`timescale 1ns / 1ps
// Self-checking testbench for mandelbrot_escape_time: stream driver, result monitor and
// a scoreboard class that computes the escape count of each accepted point in fixed point.
// Depends on met_pkg and the mandelbrot_escape_time RTL.
module tb_mandelbrot_escape_time;
    import met_pkg::*;

    localparam int W  = MET_WORD_BITS;
    localparam int F  = MET_FRACTION_BITS;
    localparam int CW = MET_COUNT_BITS;
    localparam int SW = ((2 * W + 7) / 8) * 8;
    localparam int PW = 2 * W + 2;

    localparam int HOLD_AFTER   = 400;   // results seen before the long receiver hold-off
    localparam int HOLD_CYCLES  = 1500;
    localparam int DRAIN_CYCLES = 600;   // longer than one point takes at limit 255

    localparam logic [W-1:0] Q_MAX  = 32'h7FFF_FFFF;
    localparam logic [W-1:0] Q_MIN  = 32'h8000_0000;
    localparam logic [W-1:0] Q_ONE  = 32'h1000_0000;
    localparam logic [W-1:0] Q_TWO  = 32'h2000_0000;
    localparam logic [W-1:0] Q_ZERO = '0;

    typedef struct packed {
        logic [CW-1:0] count;
        logic          escaped;
    } escape_result_t;

    typedef enum int {
        REGION_DISK,
        REGION_BULB,
        REGION_ANY,
        REGION_EDGE
    } region_t;

    class escape_scoreboard;
        localparam logic signed [PW-1:0] SAT_MAX = {{(W + 3){1'b0}}, {(W - 1){1'b1}}};
        localparam logic signed [PW-1:0] SAT_MIN = {{(W + 3){1'b1}}, {(W - 1){1'b0}}};
        localparam logic signed [PW-1:0] RADIUS_SQ = {{(PW - 1){1'b0}}, 1'b1} << (2 * F + 2);

        escape_result_t escape_q[$];
        int errors;
        int checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        task report(input string msg);
            if (errors < 40) begin
                $display("MISMATCH at %0t ns: %s", $time, msg);
            end
            errors++;
        endtask

        function logic signed [PW-1:0] clamp_word(input logic signed [PW-1:0] v);
            if (v > SAT_MAX) begin
                return SAT_MAX;
            end else if (v < SAT_MIN) begin
                return SAT_MIN;
            end
            return v;
        endfunction

        // Iterate z = z*z + c from z = c, testing |z|^2 > 4 before each squaring.
        function escape_result_t escape_time(input logic signed [W-1:0] cr,
                                             input logic signed [W-1:0] ci,
                                             input logic [CW-1:0] limit);
            logic signed [PW-1:0] re, im, rr, ii, ri, next_re, next_im;
            escape_result_t r;
            bit done;
            int i;
            re        = PW'(cr);
            im        = PW'(ci);
            r.count   = limit;
            r.escaped = 1'b0;
            done      = 1'b0;
            for (i = 0; i < int'(limit); i++) begin
                if (!done) begin
                    rr = re * re;
                    ii = im * im;
                    ri = re * im;
                    if (rr + ii > RADIUS_SQ) begin
                        r.count   = CW'(i);
                        r.escaped = 1'b1;
                        done      = 1'b1;
                    end else begin
                        next_re = ((rr - ii) >>> F) + PW'(cr);
                        next_im = (ri >>> (F - 1)) + PW'(ci);
                        re      = clamp_word(next_re);
                        im      = clamp_word(next_im);
                    end
                end
            end
            return r;
        endfunction

        function void note_point(input logic [W-1:0] cr, input logic [W-1:0] ci,
                                 input logic [CW-1:0] limit);
            escape_q.push_back(escape_time(cr, ci, limit));
        endfunction

        task check_result(input logic [CW-1:0] count, input logic escaped);
            escape_result_t want;
            if (escape_q.size() == 0) begin
                report($sformatf("result count=%0d escaped=%0b with no point pending",
                                 count, escaped));
            end else begin
                want = escape_q.pop_front();
                checked++;
                if (count !== want.count) begin
                    report($sformatf("escape_count %0d, expected %0d", count, want.count));
                end
                if (escaped !== want.escaped) begin
                    report($sformatf("escaped %0b, expected %0b", escaped, want.escaped));
                end
            end
        endtask

        function int pending();
            return escape_q.size();
        endfunction
    endclass

    logic                aclk;
    logic                aresetn;
    logic                cfg_we;
    logic [CW-1:0]       cfg_wdata;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [SW-1:0]       s_axis_tdata;   // c_real, c_imag, zero pad
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [CW-1:0]       m_axis_tdata;   // escape_count
    logic                m_axis_tuser;   // escaped

    escape_scoreboard board;
    logic [CW-1:0]    cur_limit;
    bit               calm;
    bit               held;
    int               points_sent;
    int               results_seen;
    int               limits_used;

    mandelbrot_escape_time DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        aclk = 1'b0;
    end

    always #10 aclk = ~aclk;

    // Enter and leave at a falling edge; valid stays high for a following point.
    task automatic send_point(input logic [W-1:0] cr, input logic [W-1:0] ci);
        while (!calm && $urandom_range(99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= SW'({ci, cr});
        @(posedge aclk);
        while (!s_axis_tready) begin
            @(posedge aclk);
        end
        board.note_point(cr, ci, cur_limit);
        points_sent++;
        @(negedge aclk);
    endtask

    // Drain the block, then write the limit while it is idle.
    task automatic set_limit(input logic [CW-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) begin
            @(negedge aclk);
        end
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        cur_limit = value;
        limits_used++;
    endtask

    function automatic logic [W-1:0] edge_value();
        case ($urandom_range(9))
            0: return Q_MAX;
            1: return Q_MIN;
            2: return Q_ZERO;
            3: return Q_TWO;
            4: return -Q_TWO;
            5: return Q_TWO + 1;
            6: return -Q_TWO - 1;
            7: return 32'h0000_0001;
            8: return 32'hFFFF_FFFF;
            default: return Q_ONE;
        endcase
    endfunction

    // Mostly points near the set, where counts vary; some full-range and edge values.
    function automatic logic [2*W-1:0] random_point();
        logic [W-1:0] re, im;
        int unsigned pick;
        region_t region;
        pick = $urandom_range(99);
        if (pick < 45) begin
            region = REGION_DISK;
        end else if (pick < 70) begin
            region = REGION_BULB;
        end else if (pick < 85) begin
            region = REGION_ANY;
        end else begin
            region = REGION_EDGE;
        end
        case (region)
            REGION_DISK: begin
                re = $urandom_range(32'h4000_0000) - Q_TWO;
                im = $urandom_range(32'h4000_0000) - Q_TWO;
            end
            REGION_BULB: begin
                re = 32'hF400_0000 + $urandom_range(32'h1000_0000) - 32'h0800_0000;
                im = $urandom_range(32'h0A00_0000) - 32'h0500_0000;
            end
            REGION_ANY: begin
                re = $urandom;
                im = $urandom;
            end
            default: begin
                re = edge_value();
                im = edge_value();
            end
        endcase
        return {im, re};
    endfunction

    task automatic send_random(input int count);
        logic [2*W-1:0] pt;
        int k;
        for (k = 0; k < count; k++) begin
            pt = random_point();
            send_point(pt[W-1:0], pt[2*W-1:W]);
        end
    endtask

    // Receiver: random stalls, one long hold-off once the block is well under way.
    initial begin
        m_axis_tready = 1'b0;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && results_seen >= HOLD_AFTER) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_axis_tready <= calm || ($urandom_range(99) >= 35);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            board.check_result(m_axis_tdata, m_axis_tuser);
            results_seen++;
        end
    end

    initial begin
        #60_000_000;
        $display("FAIL mandelbrot_escape_time");
        $finish;
    end

    initial begin
        board         = new();
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cur_limit     = MET_LIMIT_RESET;
        calm          = 1'b0;
        points_sent   = 0;
        results_seen  = 0;
        limits_used   = 1;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset limit: extremes, the radius-two boundary and known interior points.
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_MAX, Q_MAX);
        send_point(Q_MIN, Q_MIN);
        send_point(Q_MIN, Q_ZERO);
        send_point(Q_ZERO, Q_MAX);
        send_point(Q_MAX, Q_MIN);
        send_point(Q_TWO, Q_ZERO);
        send_point(Q_TWO + 1, Q_ZERO);
        send_point(-Q_TWO, Q_ZERO);
        send_point(-Q_TWO, 32'h0000_0001);
        send_point(Q_ZERO, Q_TWO);
        send_point(Q_ZERO, -Q_TWO);
        send_point(-Q_ONE, Q_ZERO);
        send_point(Q_ZERO, Q_ONE);
        send_point(32'h0400_0000, Q_ZERO);
        send_point(32'h0428_F5C3, Q_ZERO);
        send_point(32'hF400_0000, 32'h0199_999A);
        send_point(32'h04CC_CCCD, 32'h0800_0000);
        send_point(32'hE800_0000, Q_ZERO);
        send_point(32'h0000_0001, 32'hFFFF_FFFF);

        // Limit of zero: no test at all.
        set_limit(8'd0);
        send_point(Q_ZERO, Q_ZERO);
        send_point(Q_MAX, Q_MIN);
        send_random(40);

        set_limit(8'd1);
        send_point(Q_TWO + 1, Q_ZERO);
        send_point(Q_ZERO, Q_ZERO);
        send_random(100);

        // Escape on the last test: 2 + 0i escapes at the second test.
        set_limit(8'd2);
        send_point(Q_TWO, Q_ZERO);
        send_point(Q_ZERO, Q_TWO);
        send_random(200);

        set_limit(8'd255);
        send_point(Q_ZERO, Q_ZERO);
        send_point(-Q_TWO, Q_ZERO);
        send_random(60);

        for (int p = 0; p < 6; p++) begin
            set_limit(CW'($urandom_range(3, 64)));
            calm = (p == 1);
            send_random(265);
        end
        calm = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (board.pending() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.pending() != 0) begin
            board.report($sformatf("%0d results never arrived", board.pending()));
        end

        $display("Sent %0d points under %0d iteration limits (0, 1, 2, 255 and random)",
                 points_sent, limits_used);
        $display("Checked %0d results across idle gaps, stalls and a %0d-cycle hold-off",
                 board.checked, HOLD_CYCLES);
        if (board.errors == 0) begin
            $display("PASS mandelbrot_escape_time");
        end else begin
            $display("FAIL mandelbrot_escape_time");
        end
        $finish;
    end

endmodule
